FILE: hw/rtl/vdi_pkg.sv
// Shared constants, types and controller/datapath signal groups for the
// vertex deduplication indexer. No dependencies.
package vdi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ATTR_W      = 32;
   localparam int KEY_W       = 8 * ATTR_W;
   localparam int OUT_IDX_W   = 10;
   localparam int IDX_EXT_W   = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish_hit;
      logic finish_miss;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
   } status_type;

endpackage

FILE: hw/rtl/vdi_if.sv
// Handshake channels of the vertex deduplication indexer: vertex words in
// and index words out. Depends on vdi_pkg.
interface vdi_req_if import vdi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              start_of_mesh;
   logic [ATTR_W-1:0] pos_x;
   logic [ATTR_W-1:0] pos_y;
   logic [ATTR_W-1:0] pos_z;
   logic [ATTR_W-1:0] tex_u;
   logic [ATTR_W-1:0] tex_v;
   logic [ATTR_W-1:0] norm_x;
   logic [ATTR_W-1:0] norm_y;
   logic [ATTR_W-1:0] norm_z;

   modport source (output valid, start_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                   norm_x, norm_y, norm_z, input ready);
   modport sink (input valid, start_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                 norm_x, norm_y, norm_z, output ready);
endinterface

interface vdi_rsp_if import vdi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] vertex_index;
   logic                 is_new;
   logic                 table_full;

   modport source (output valid, vertex_index, is_new, table_full, input ready);
   modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface

FILE: hw/rtl/vdi_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module vdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/vdi_datapath.sv
// Datapath: key register, unique-vertex count, scan pointer, key table RAM
// and result registers. Depends on vdi_pkg and vdi_ram.
module vdi_datapath import vdi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 start_of_mesh,
   input  logic [KEY_W-1:0]     key,
   output logic [OUT_IDX_W-1:0] vertex_index,
   output logic                 is_new,
   output logic                 table_full
);

   logic [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0] res_idx_ff, res_idx_in;
   logic             res_new_ff, res_new_in;
   logic             res_full_ff, res_full_in;
   logic             rd_en;
   logic             wr_en;
   logic             has_room;
   logic [KEY_W-1:0] rd_data;
   logic [IDX_EXT_W-1:0] idx_ext;

   assign has_room = (count_ff < CNT_W'(TABLE_DEPTH));
   // Entries below the count are exactly the valid ones, in insertion order.
   assign rd_en    = cmd.scan && (scan_ff < count_ff);
   assign wr_en    = cmd.finish_miss && has_room;

   assign status.hit       = rd_pend_ff && (rd_data == key_ff);
   assign status.scan_done = (scan_ff >= count_ff) && !rd_pend_ff;

   vdi_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in    = count_ff;
      scan_in     = scan_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = rd_pend_ff;
      res_idx_in  = res_idx_ff;
      res_new_in  = res_new_ff;
      res_full_in = res_full_ff;
      if (cmd.load) begin
         scan_in    = '0;
         rd_pend_in = 1'b0;
         if (start_of_mesh) begin
            count_in = '0;
         end
      end else if (cmd.scan) begin
         rd_pend_in = rd_en;
         if (rd_en) begin
            rd_idx_in = scan_ff[IDX_W-1:0];
            scan_in   = scan_ff + CNT_W'(1);
         end
      end
      if (cmd.finish_hit) begin
         res_idx_in  = CNT_W'(rd_idx_ff);
         res_new_in  = 1'b0;
         res_full_in = 1'b0;
      end else if (cmd.finish_miss) begin
         if (has_room) begin
            res_idx_in  = count_ff;
            res_new_in  = 1'b1;
            res_full_in = 1'b0;
            count_in    = count_ff + CNT_W'(1);
         end else begin
            res_idx_in  = '0;
            res_new_in  = 1'b0;
            res_full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
         scan_ff    <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key;
      end
      rd_idx_ff   <= rd_idx_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
   end

   // The reported index is the table index taken modulo 1024.
   assign idx_ext      = IDX_EXT_W'(res_idx_ff);
   assign vertex_index = idx_ext[OUT_IDX_W-1:0];
   assign is_new       = res_new_ff;
   assign table_full   = res_full_ff;

endmodule

FILE: hw/rtl/vdi_ctrl.sv
// Controller state machine: takes a vertex word, runs the table scan and
// holds the result word until it is taken. Depends on vdi_pkg.
module vdi_ctrl import vdi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit) begin
               cmd.finish_hit = 1'b1;
               state_in       = ST_RESP;
            end else if (status.scan_done) begin
               cmd.finish_miss = 1'b1;
               state_in        = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/vertex_dedup_indexer.sv
// Vertex deduplication indexer. Each vertex word (eight raw 32-bit attribute
// patterns) is looked up in a table of unique vertices by exact 256-bit
// equality. A hit returns the stored index; a miss stores the vertex under the
// next free index and raises is_new; when the table is full the result is
// index 0 with table_full set. start_of_mesh empties the table first. The
// table is one key RAM scanned one entry per cycle, and that scan sets the
// time for an item: a hit at index i ends the scan once entry i has been read,
// and a miss ends it only after every stored entry has been read, so a full
// table gives the longest scan. The next vertex word can be accepted in the
// cycle after the result word is taken. One vertex is in flight at a time.
// No clearing pass is run after reset. Depends on vdi_pkg, vdi_if, vdi_ctrl
// and vdi_datapath.
module vertex_dedup_indexer import vdi_pkg::*; (
   input logic      clock,
   input logic      reset,
   vdi_req_if.sink  req_port,
   vdi_rsp_if.source rsp_port
);

   cmd_type    cmd;
   status_type status;

   vdi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vdi_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .start_of_mesh (req_port.start_of_mesh),
      .key           ({req_port.norm_z, req_port.norm_y, req_port.norm_x,
                       req_port.tex_v, req_port.tex_u,
                       req_port.pos_z, req_port.pos_y, req_port.pos_x}),
      .vertex_index  (rsp_port.vertex_index),
      .is_new        (rsp_port.is_new),
      .table_full    (rsp_port.table_full)
   );

endmodule

FILE: sim/tb_vertex_dedup_indexer.sv
// Self-checking testbench for vertex_dedup_indexer: drives vertex words, keeps
// its own table of unique vertices and checks every index word that comes back.
// Depends on vdi_pkg, vdi_if and the RTL of the block.
module tb_vertex_dedup_indexer import vdi_pkg::*; ();

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int ATTR_N      = 8;

   // Attribute order: pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z.
   typedef logic [ATTR_N-1:0][ATTR_W-1:0] attr_set_type;

   typedef struct packed {
      logic         drain_first;
      logic         start_of_mesh;
      attr_set_type attr;
   } vertex_word_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] vertex_index;
      logic                 is_new;
      logic                 table_full;
   } index_word_type;

   logic clock;
   logic reset;

   vdi_req_if req_if ();
   vdi_rsp_if rsp_if ();

   vertex_dedup_indexer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   vertex_word_type vertex_backlog[$];
   attr_set_type    mesh_vertices[$];
   index_word_type  awaited_indices[$];

   attr_set_type known_vertices [TABLE_DEPTH];
   int           known_count;

   int   error_count;
   int   cycle_count;
   int   vertices_total;
   int   vertices_taken;
   int   words_seen;
   logic req_took;
   int   send_gap;
   int   rsp_stall;
   bit   sender_calm;
   bit   receiver_calm;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count++;

   function automatic index_word_type index_vertex(input logic som, input attr_set_type key);
      index_word_type res;
      int             hit_at;
      res    = '0;
      hit_at = -1;
      if (som)
         known_count = 0;
      for (int i = 0; i < known_count; i++) begin
         if (known_vertices[i] == key) begin
            hit_at = i;
            break;
         end
      end
      if (hit_at >= 0) begin
         res.vertex_index = OUT_IDX_W'(hit_at);
      end else if (known_count < TABLE_DEPTH) begin
         known_vertices[known_count] = key;
         res.vertex_index = OUT_IDX_W'(known_count);
         res.is_new = 1'b1;
         known_count++;
      end else begin
         res.table_full = 1'b1;
      end
      return res;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("%s", msg);
   endtask

   // Back-to-back or a short gap most of the time, sometimes a longer gap and the odd long one.
   function automatic int pick_gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Common float patterns, so that vertices often share some attributes.
   function automatic logic [ATTR_W-1:0] pick_attr();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7FC0_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h3F80_0000;
         5: return 32'hBF80_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic attr_set_type random_attrs(input bit palette);
      attr_set_type a;
      foreach (a[k])
         a[k] = palette ? pick_attr() : $urandom();
      return a;
   endfunction

   task automatic queue_vertex(input logic som, input logic drain, input attr_set_type a);
      vertex_word_type w;
      w.start_of_mesh = som;
      w.drain_first   = drain;
      w.attr          = a;
      vertex_backlog  = {vertex_backlog, w};
   endtask

   // One vertex of a mesh: a repeat of an earlier one, a copy with one bit
   // flipped, or a fresh vertex that joins the pool for later repeats.
   task automatic mesh_item(input logic som, input logic drain, input bit palette,
                            input int reuse_pct);
      attr_set_type a;
      int           sel;
      sel = $urandom_range(0, 99);
      if (som)
         mesh_vertices.delete();
      if (mesh_vertices.size() != 0 && sel < reuse_pct) begin
         a = mesh_vertices[$urandom_range(0, mesh_vertices.size() - 1)];
      end else if (mesh_vertices.size() != 0 && sel < reuse_pct + 5) begin
         a = mesh_vertices[$urandom_range(0, mesh_vertices.size() - 1)];
         a[$urandom_range(0, ATTR_N - 1)][$urandom_range(0, ATTR_W - 1)] ^= 1'b1;
      end else begin
         a = random_attrs(palette);
         mesh_vertices = {mesh_vertices, a};
      end
      queue_vertex(som, drain, a);
   endtask

   always @(negedge clock) begin : sender
      vertex_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_if.valid || req_took) begin
         if (req_took && !sender_calm)
            send_gap = pick_gap_len();
         if (req_took && $urandom_range(0, 99) == 0)
            sender_calm = !sender_calm;
         if (send_gap != 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (vertex_backlog.size() != 0 &&
                      !(vertex_backlog[0].drain_first && awaited_indices.size() != 0)) begin
            w = vertex_backlog.pop_front();
            req_if.start_of_mesh <= w.start_of_mesh;
            req_if.pos_x  <= w.attr[0];
            req_if.pos_y  <= w.attr[1];
            req_if.pos_z  <= w.attr[2];
            req_if.tex_u  <= w.attr[3];
            req_if.tex_v  <= w.attr[4];
            req_if.norm_x <= w.attr[5];
            req_if.norm_y <= w.attr[6];
            req_if.norm_z <= w.attr[7];
            req_if.valid  <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_stall != 0)
            rsp_stall--;
         else if (!receiver_calm && $urandom_range(0, 5) == 0)
            rsp_stall = pick_gap_len();
         rsp_if.ready <= (rsp_stall == 0);
         if ($urandom_range(0, 499) == 0)
            receiver_calm = !receiver_calm;
      end
   end

   always @(posedge clock) begin : observer
      attr_set_type   seen;
      index_word_type want;
      index_word_type got;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_if.valid && req_if.ready;
         // The result side is checked first, so a stray word can never be
         // matched against a vertex taken on the same edge.
         if (rsp_if.valid && rsp_if.ready) begin
            got.vertex_index = rsp_if.vertex_index;
            got.is_new       = rsp_if.is_new;
            got.table_full   = rsp_if.table_full;
            if (awaited_indices.size() == 0) begin
               note_failure($sformatf("index word %0d arrived with no vertex awaiting it",
                                      words_seen));
            end else begin
               want = awaited_indices.pop_front();
               if (got.vertex_index !== want.vertex_index || got.is_new !== want.is_new ||
                   got.table_full !== want.table_full)
                  note_failure($sformatf(
                     "index word %0d: want index %0d new %0b full %0b, got %0d %0b %0b",
                     words_seen, want.vertex_index, want.is_new, want.table_full,
                     got.vertex_index, got.is_new, got.table_full));
            end
            words_seen++;
         end
         if (req_if.valid && req_if.ready) begin
            seen = {req_if.norm_z, req_if.norm_y, req_if.norm_x, req_if.tex_v,
                    req_if.tex_u, req_if.pos_z, req_if.pos_y, req_if.pos_x};
            want = index_vertex(req_if.start_of_mesh, seen);
            awaited_indices = {awaited_indices, want};
            vertices_taken++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      attr_set_type a;
      int           mesh_len;

      clock = 1'b0;
      reset = 1'b1;
      req_if.valid         = 1'b0;
      req_if.start_of_mesh = 1'b0;
      req_if.pos_x  = '0;
      req_if.pos_y  = '0;
      req_if.pos_z  = '0;
      req_if.tex_u  = '0;
      req_if.tex_v  = '0;
      req_if.norm_x = '0;
      req_if.norm_y = '0;
      req_if.norm_z = '0;
      rsp_if.ready  = 1'b0;
      error_count = 0;
      cycle_count = 0;
      known_count = 0;
      vertices_taken = 0;
      words_seen = 0;
      sender_calm = 1'b0;
      receiver_calm = 1'b0;

      // Directed: zeros and ones, signed zero, NaN payloads, one-attribute
      // differences and clearing of the table at the start of a mesh.
      queue_vertex(1'b1, 1'b0, {ATTR_N{32'h0000_0000}});
      queue_vertex(1'b0, 1'b0, {ATTR_N{32'h0000_0000}});
      a = '0;
      a[0] = 32'h8000_0000;
      queue_vertex(1'b0, 1'b0, a);
      queue_vertex(1'b0, 1'b0, {ATTR_N{32'hFFFF_FFFF}});
      a = '0;
      a[7] = 32'h7FC0_0000;
      queue_vertex(1'b0, 1'b0, a);
      queue_vertex(1'b0, 1'b0, a);
      a[7] = 32'h7FC0_0001;
      queue_vertex(1'b0, 1'b0, a);
      for (int k = 1; k < ATTR_N; k++) begin
         a = '0;
         a[k] = 32'h1 << (k * 4);
         queue_vertex(1'b0, 1'b0, a);
      end
      queue_vertex(1'b0, 1'b0, {ATTR_N{32'hFFFF_FFFF}});
      queue_vertex(1'b0, 1'b0, {ATTR_N{32'h0000_0000}});
      queue_vertex(1'b1, 1'b0, {ATTR_N{32'hFFFF_FFFF}});
      queue_vertex(1'b0, 1'b0, {ATTR_N{32'h0000_0000}});
      queue_vertex(1'b1, 1'b1, {ATTR_N{32'hFFFF_FFFF}});

      // Small meshes with plenty of shared vertices.
      while (vertex_backlog.size() < 270) begin
         mesh_len = $urandom_range(1, 40);
         mesh_item(1'b1, $urandom_range(0, 3) == 0, 1'b1, 40);
         repeat (mesh_len - 1)
            mesh_item(1'b0, 1'b0, 1'b1, 40);
      end

      // One mesh large enough to fill the table, then lookups on a full table.
      mesh_item(1'b1, 1'b1, 1'b0, 8);
      while (mesh_vertices.size() < TABLE_DEPTH + 30)
         mesh_item(1'b0, 1'b0, 1'b0, 8);
      repeat (40)
         mesh_item(1'b0, 1'b0, 1'b0, 60);

      while (vertex_backlog.size() < 1650) begin
         mesh_len = $urandom_range(1, 40);
         mesh_item(1'b1, $urandom_range(0, 3) == 0, 1'b1, 40);
         repeat (mesh_len - 1)
            mesh_item(1'b0, 1'b0, 1'b1, 40);
      end
      vertices_total = vertex_backlog.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (vertices_taken < vertices_total || awaited_indices.size() != 0)
         @(negedge clock);
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (awaited_indices.size() != 0)
         note_failure($sformatf("%0d index words never arrived", awaited_indices.size()));

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: vertex_dedup_indexer.f
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_if.sv
hw/rtl/vdi_ram.sv
hw/rtl/vdi_datapath.sv
hw/rtl/vdi_ctrl.sv
hw/rtl/vertex_dedup_indexer.sv
sim/tb_vertex_dedup_indexer.sv
